@@ hdl/cbis_pkg.sv @@
// Package for the CBOR item skipper: walk phase codes, error codes, limits,
// and the walk state and result record types. It depends on nothing else.
package cbis_pkg;

	localparam int unsigned ArgW     = 32;
	localparam int unsigned PendW    = 16;
	localparam int unsigned ResultW  = 40;

	localparam logic [4:0] AiOneByte  = 5'd24;
	localparam logic [4:0] AiTwoByte  = 5'd25;
	localparam logic [4:0] AiFourByte = 5'd26;

	localparam logic [ArgW-1:0] ArrayMax = 32'h0000_FFFF;
	localparam logic [ArgW-1:0] MapMax   = 32'h0000_7FFF;
	localparam logic [17:0]     PendMax  = 18'h0_FFFF;

	localparam logic [2:0] MtBytes = 3'd2;
	localparam logic [2:0] MtText  = 3'd3;
	localparam logic [2:0] MtArray = 3'd4;
	localparam logic [2:0] MtMap   = 3'd5;

	typedef enum logic [3:0] {
		PH_HEAD    = 4'b0001,
		PH_ARG     = 4'b0010,
		PH_PAYLOAD = 4'b0100,
		PH_IDLE    = 4'b1000
	} phase_t;

	typedef enum logic [2:0] {
		ERR_NONE    = 3'd0,
		ERR_INFO    = 3'd1,
		ERR_TRUNC   = 3'd2,
		ERR_ARRAY   = 3'd3,
		ERR_MAP     = 3'd4,
		ERR_PENDING = 3'd5
	} err_t;

	typedef struct packed {
		phase_t            phase;
		logic [2:0]        held_major;
		logic [2:0]        arg_left;
		logic [ArgW-1:0]   acc;
		logic [ArgW-1:0]   payload_left;
		logic [PendW-1:0]  pending;
	} walk_state_t;

	// Packed so that head_valid lands in bit 0 of the stream word.
	typedef struct packed {
		err_t              error_code;
		logic              item_done;
		logic [ArgW-1:0]   argument;
		logic [2:0]        major_type;
		logic              head_valid;
	} result_t;

	localparam walk_state_t WalkRestart = '{
		phase:        PH_HEAD,
		held_major:   3'd0,
		arg_left:     3'd0,
		acc:          '0,
		payload_left: '0,
		pending:      16'd1
	};

endpackage

@@ hdl/cbis_walk.sv @@
// Next-state and result logic for one byte of the CBOR item walk.
// Purely combinational; uses the types and constants of cbis_pkg.
module cbis_walk import cbis_pkg::*; (
	input  walk_state_t st,
	input  logic [7:0]  data_byte,
	input  logic        last_byte,
	output walk_state_t nxt,
	output logic        res_valid,
	output result_t     res
);

	logic [2:0]      mt_b;
	logic [4:0]      ai;
	logic [ArgW-1:0] acc_new;
	logic [2:0]      left_new;
	logic [ArgW-1:0] pl_new;
	logic            head_go;
	logic [2:0]      head_mt;
	logic [ArgW-1:0] head_v;
	logic            fin_go;
	logic [17:0]     pend_base;
	logic [17:0]     pend_add;
	logic [17:0]     pend_sum;

	assign mt_b     = data_byte[7:5];
	assign ai       = data_byte[4:0];
	assign acc_new  = {st.acc[ArgW-9:0], data_byte};
	assign left_new = st.arg_left - 3'd1;
	assign pl_new   = (st.payload_left != '0) ? st.payload_left - 1'b1 : st.payload_left;

	always_comb begin
		nxt       = st;
		res_valid = 1'b0;
		res       = '0;
		head_go   = 1'b0;
		head_mt   = st.held_major;
		head_v    = '0;
		fin_go    = 1'b0;
		pend_base = {2'b00, st.pending} - 18'd1;
		pend_add  = '0;
		pend_sum  = '0;

		case (st.phase)
			PH_IDLE: begin
				if (last_byte) nxt = WalkRestart;
			end
			PH_HEAD: begin
				nxt.held_major = mt_b;
				nxt.acc        = '0;
				if (ai < AiOneByte) begin
					head_go = 1'b1;
					head_mt = mt_b;
					head_v  = {{(ArgW-5){1'b0}}, ai};
				end else if (ai > AiFourByte) begin
					nxt.held_major = st.held_major;
					nxt.acc        = st.acc;
					fin_go         = 1'b1;
					res            = '{ERR_INFO, 1'b0, '0, mt_b, 1'b0};
				end else begin
					case (ai)
						AiOneByte: nxt.arg_left = 3'd1;
						AiTwoByte: nxt.arg_left = 3'd2;
						default:   nxt.arg_left = 3'd4;
					endcase
					if (last_byte) begin
						fin_go = 1'b1;
						res    = '{ERR_TRUNC, 1'b0, '0, mt_b, 1'b0};
					end else begin
						nxt.phase = PH_ARG;
					end
				end
			end
			PH_ARG: begin
				nxt.acc      = acc_new;
				nxt.arg_left = left_new;
				if (left_new == 3'd0) begin
					head_go = 1'b1;
					head_mt = st.held_major;
					head_v  = acc_new;
				end else if (last_byte) begin
					fin_go = 1'b1;
					res    = '{ERR_TRUNC, 1'b0, '0, st.held_major, 1'b0};
				end
			end
			PH_PAYLOAD: begin
				nxt.payload_left = pl_new;
				if (pl_new == '0) begin
					if (st.pending == '0) begin
						fin_go = 1'b1;
						res    = '{ERR_NONE, 1'b1, st.acc, st.held_major, 1'b0};
					end else if (last_byte) begin
						fin_go = 1'b1;
						res    = '{ERR_TRUNC, 1'b0, st.acc, st.held_major, 1'b0};
					end else begin
						nxt.phase = PH_HEAD;
					end
				end else if (last_byte) begin
					fin_go = 1'b1;
					res    = '{ERR_TRUNC, 1'b0, st.acc, st.held_major, 1'b0};
				end
			end
			default: nxt = WalkRestart;
		endcase

		// A head finished on this byte: account for it in the pending count.
		if (head_go) begin
			nxt.held_major = head_mt;
			nxt.acc        = head_v;
			nxt.arg_left   = 3'd0;
			if (head_mt == MtArray) pend_add = {2'b00, head_v[15:0]};
			else if (head_mt == MtMap) pend_add = {2'b00, head_v[14:0], 1'b0};
			pend_sum = pend_base + pend_add;

			if ((head_mt == MtBytes || head_mt == MtText) && head_v != '0) begin
				if (last_byte) begin
					fin_go = 1'b1;
					res    = '{ERR_TRUNC, 1'b0, head_v, head_mt, 1'b1};
				end else begin
					nxt.pending      = pend_base[PendW-1:0];
					nxt.payload_left = head_v;
					nxt.phase        = PH_PAYLOAD;
					res_valid        = 1'b1;
					res              = '{ERR_NONE, 1'b0, head_v, head_mt, 1'b1};
				end
			end else if (head_mt == MtArray && head_v > ArrayMax) begin
				fin_go = 1'b1;
				res    = '{ERR_ARRAY, 1'b0, head_v, head_mt, 1'b1};
			end else if (head_mt == MtMap && head_v > MapMax) begin
				fin_go = 1'b1;
				res    = '{ERR_MAP, 1'b0, head_v, head_mt, 1'b1};
			end else if (pend_sum > PendMax) begin
				fin_go = 1'b1;
				res    = '{ERR_PENDING, 1'b0, head_v, head_mt, 1'b1};
			end else begin
				nxt.pending = pend_sum[PendW-1:0];
				if (pend_sum == '0) begin
					fin_go = 1'b1;
					res    = '{ERR_NONE, 1'b1, head_v, head_mt, 1'b1};
				end else if (last_byte) begin
					fin_go = 1'b1;
					res    = '{ERR_TRUNC, 1'b0, head_v, head_mt, 1'b1};
				end else begin
					nxt.phase = PH_HEAD;
					res_valid = 1'b1;
					res       = '{ERR_NONE, 1'b0, head_v, head_mt, 1'b1};
				end
			end
		end

		// Completion or error: park until the last byte, or restart right away.
		if (fin_go) begin
			res_valid = 1'b1;
			nxt.phase = PH_IDLE;
			if (last_byte) nxt = WalkRestart;
		end
	end

endmodule

@@ hdl/cbor_item_skipper.sv @@
// Top level of the CBOR item skipper: stream ports, walk state register,
// and a two-entry output stage. Depends on cbis_pkg and cbis_walk.
//
// The block walks one complete top-level CBOR data item, taking the buffer
// one byte per transaction on the slave side (s_tdata carries the byte,
// s_tlast marks the final byte of the buffer). It takes one byte every clock
// cycle while s_tready is high: the walk state (phase, argument accumulator,
// string payload count and pending-item count) is updated by a single pass
// of logic per byte, and that state loop is what sets the rate. Bytes that
// complete a head, finish the item or raise an error produce one result
// transaction on the master side; all other bytes produce none. Results go
// into an output register backed by a skid register, so a stalled consumer
// stops byte intake only once both are full, and s_tready is a plain
// register output. After completion or an error, bytes are swallowed until
// the buffer's last byte, which restarts the walk. Heads with additional
// info 27 to 31 are rejected, arrays above 65535 elements and maps above
// 32767 pairs are refused, and the pending item count is limited to 65535.
module cbor_item_skipper import cbis_pkg::*; (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               s_tvalid,
	output logic               s_tready,
	input  logic [7:0]         s_tdata,  // [7:0] data_byte
	input  logic               s_tlast,  // last_byte
	output logic               m_tvalid,
	input  logic               m_tready,
	// [0] head_valid, [3:1] major_type, [35:4] argument, [36] item_done,
	// [39:37] error_code
	output logic [ResultW-1:0] m_tdata
);

	walk_state_t st_q;
	walk_state_t st_nxt;
	logic        has_res;
	result_t     res;
	result_t     out_q;
	result_t     skid_q;
	logic        out_valid_q;
	logic        skid_valid_q;
	logic        accept;
	logic        push;
	logic        pop;

	// Room for a result is guaranteed whenever the skid register is empty.
	assign s_tready = !skid_valid_q;
	assign accept   = s_tvalid && s_tready;
	assign push     = accept && has_res;
	assign pop      = out_valid_q && m_tready;
	assign m_tvalid = out_valid_q;
	assign m_tdata  = out_q;

	cbis_walk u_walk (
		.st        (st_q),
		.data_byte (s_tdata),
		.last_byte (s_tlast),
		.nxt       (st_nxt),
		.res_valid (has_res),
		.res       (res)
	);

	// The walk state only moves when a byte is taken.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			st_q <= WalkRestart;
		end else if (accept) begin
			st_q <= st_nxt;
		end
	end

	// Output register with a skid register behind it.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q  <= 1'b0;
			skid_valid_q <= 1'b0;
		end else if (skid_valid_q) begin
			if (pop) begin
				out_valid_q  <= 1'b1;
				skid_valid_q <= 1'b0;
			end
		end else if (push) begin
			if (!out_valid_q || pop) begin
				out_valid_q <= 1'b1;
			end else begin
				skid_valid_q <= 1'b1;
			end
		end else if (pop) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (skid_valid_q) begin
			if (pop) out_q <= skid_q;
		end else if (push) begin
			if (!out_valid_q || pop) out_q <= res;
			else skid_q <= res;
		end
	end

	// The skid register is only ever filled behind a waiting result.
	assert property (@(posedge clk) disable iff (!arst_n)
		skid_valid_q |-> out_valid_q)
		else $error("skid register holds a result while the output is empty");

	// A result taken while the output is stalled must land in the skid register.
	assert property (@(posedge clk) disable iff (!arst_n)
		(push && out_valid_q && !m_tready) |=> skid_valid_q)
		else $error("result lost while the output was stalled");

	// Bytes after completion or an error never produce a result.
	assert property (@(posedge clk) disable iff (!arst_n)
		(accept && st_q.phase == PH_IDLE) |-> !has_res)
		else $error("result produced while the walk was parked");

	// A finished item is never reported together with an error.
	assert property (@(posedge clk) disable iff (!arst_n)
		(m_tvalid && out_q.item_done) |-> (out_q.error_code == ERR_NONE))
		else $error("item completion reported with an error code");

endmodule
